// ----- hw/rtl/lrgs_pkg.sv -----
// Package for the linear regression gradient step block.
// Holds payload structs, operation and register codes, and saturation helpers.
// No dependencies.
package lrgs_pkg;

  // Operation codes carried in the input transaction
  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_FEATURE     = 2'd1,
    OP_TARGET      = 2'd2,
    OP_STEP        = 2'd3
  } op_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 4'd1;

  // Register reset values
  localparam logic [3:0]  FEATURE_COUNT_RST = 4'd1;
  localparam logic [31:0] LEARNING_RATE_RST = 32'd429497;

  // 1.0 in Q16.16 as a multiplier operand
  localparam logic signed [32:0] Q_ONE = 33'sd65536;

  localparam logic signed [49:0] S32_MAX50 = 50'sd2147483647;
  localparam logic signed [49:0] S32_MIN50 = -50'sd2147483648;

  typedef struct packed {
    op_e                op;
    logic [3:0]         index;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [3:0]         weight_index;
    logic signed [31:0] weight_value;
    logic               last;
  } out_t;

  // Clamp a wide signed value to the 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX50) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN50) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Signed 64-bit add that clamps on overflow
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    logic signed [63:0] r;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      r = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/linear_regression_gradient_step_top.sv -----
// Top level of the linear regression gradient step block (Q16.16).
// Depends on lrgs_pkg and lrgs_ram.
// Input channel (in_valid_i/in_ready_o, in_data_i) carries one transaction per
// operation: load weight, feature value, target (closes a sample) or step.
// Output channel (out_valid_o/out_ready_i, out_data_o) carries the updated
// weights of a step, index 0 (bias) to n, with last set on weight n, where
// n = min(feature_count, MAX_FEATURES). Config channel (cfg_valid_i/cfg_ready_o)
// writes feature_count (index 0) and learning_rate (index 1); it is always
// ready and is to be used while idle; the block itself does not enforce this.
// Transactions: load weight and feature write storage directly; target runs
// the prediction (read, multiply, accumulate per weight), the error and the
// gradient update (read, multiply, accumulate per weight), all through one
// shared 33x33 multiplier and 64-bit saturating adds; step runs the weight
// update per weight (two multiplier passes per weight) and waits on output
// stalls, offering one weight per pass through the update states.
// in_ready_o is high only while the sequencer is idle; the final weight may
// still wait in the output register while the next transaction is taken.
// Reset clears the gradient sums (through valid bits), the configuration
// registers and the handshake state; weights and features are undefined until
// loaded. A stalled receiver holds the step sequence at the current weight.
module linear_regression_gradient_step_top #(
  parameter int unsigned MAX_FEATURES = 15
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  lrgs_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output lrgs_pkg::out_t                       out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lrgs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [31:0]                          cfg_data_i
);

  localparam int unsigned DEPTH = MAX_FEATURES + 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_P_RD  = 4'd1;
  localparam logic [3:0] S_P_MUL = 4'd2;
  localparam logic [3:0] S_P_ACC = 4'd3;
  localparam logic [3:0] S_ERR   = 4'd4;
  localparam logic [3:0] S_G_RD  = 4'd5;
  localparam logic [3:0] S_G_MUL = 4'd6;
  localparam logic [3:0] S_G_ACC = 4'd7;
  localparam logic [3:0] S_U_RD  = 4'd8;
  localparam logic [3:0] S_U_LO  = 4'd9;
  localparam logic [3:0] S_U_M1  = 4'd10;
  localparam logic [3:0] S_U_M2  = 4'd11;
  localparam logic [3:0] S_U_SUM = 4'd12;
  localparam logic [3:0] S_U_OUT = 4'd13;

  logic [3:0]  state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] n_act;
  logic [3:0]  fcount_q;
  logic [31:0] alpha_q;
  logic [DEPTH-1:0] gvalid_q, gvalid_d;

  logic signed [31:0] target_q;
  logic signed [63:0] acc_q, acc_d;
  logic signed [31:0] err_q;
  logic signed [63:0] g_q;
  logic signed [31:0] w_q;
  logic               neg_q;
  logic [63:0]        mag_q;
  logic [63:0]        lo_q;
  logic signed [49:0] dlt_q;
  logic signed [65:0] mul_q;
  logic signed [32:0] mul_a, mul_b;

  logic out_valid_q;
  lrgs_pkg::out_t out_q;

  logic          in_fire;
  logic          out_free;
  logic          idx_ok;
  logic [AW-1:0] in_addr;

  // RAM ports
  logic          w_we, x_we, g_we;
  logic [AW-1:0] w_waddr;
  logic [31:0]   w_wdata;
  logic [63:0]   g_wdata;
  logic [31:0]   w_rd, x_rd;
  logic [63:0]   g_rd;
  logic signed [63:0] g_masked;
  logic signed [63:0] g_sum;
  logic signed [49:0] pred50;
  logic signed [31:0] pred;
  logic signed [49:0] err50;
  logic [63:0]        dsum;
  logic [47:0]        dmag;
  logic signed [49:0] nw50;
  logic signed [31:0] nw;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Highest active weight index, clamped to MAX_FEATURES (the last storage entry)
  always_comb begin
    if ({28'd0, fcount_q} > MAX_FEATURES) begin
      n_act = AW'(MAX_FEATURES);
    end else begin
      n_act = AW'(fcount_q);
    end
  end

  assign idx_ok  = ({28'd0, in_data_i.index} <= MAX_FEATURES);
  assign in_addr = AW'(in_data_i.index);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcount_q <= lrgs_pkg::FEATURE_COUNT_RST;
      alpha_q  <= lrgs_pkg::LEARNING_RATE_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == lrgs_pkg::CFG_FEATURE_COUNT) begin
        fcount_q <= cfg_data_i[3:0];
      end else if (cfg_index_i == lrgs_pkg::CFG_LEARNING_RATE) begin
        alpha_q <= cfg_data_i;
      end
    end
  end

  // Storage
  lrgs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_wram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (cnt_q),
    .rdata_o (w_rd)
  );

  lrgs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_xram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (in_addr),
    .wdata_i (in_data_i.value),
    .raddr_i (cnt_q),
    .rdata_o (x_rd)
  );

  lrgs_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_gram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (cnt_q),
    .wdata_i (g_wdata),
    .raddr_i (cnt_q),
    .rdata_o (g_rd)
  );

  // Gradient entry reads as zero until written since the last step
  assign g_masked = gvalid_q[cnt_q] ? $signed(g_rd) : 64'sd0;

  // Shared multiplier operand selection
  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    unique case (state_q)
      S_P_MUL: begin
        mul_a = {w_rd[31], w_rd};
        mul_b = (cnt_q == '0) ? lrgs_pkg::Q_ONE : $signed({x_rd[31], x_rd});
      end
      S_G_MUL: begin
        mul_a = {err_q[31], err_q};
        mul_b = (cnt_q == '0) ? lrgs_pkg::Q_ONE : $signed({x_rd[31], x_rd});
      end
      S_U_M1: begin
        mul_a = {1'b0, mag_q[31:0]};
        mul_b = {1'b0, alpha_q};
      end
      S_U_M2: begin
        mul_a = {1'b0, mag_q[63:32]};
        mul_b = {1'b0, alpha_q};
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
      end
    endcase
  end

  // Prediction and error
  assign pred50 = {{2{acc_q[63]}}, acc_q[63:16]};
  assign pred   = lrgs_pkg::sat32(pred50);
  assign err50  = {{18{pred[31]}}, pred} - {{18{target_q[31]}}, target_q};

  // Gradient accumulate
  assign g_sum   = lrgs_pkg::sat_add64(g_q, mul_q[63:0]);
  assign g_wdata = g_sum;

  // Scaled step size and new weight
  assign dsum = mul_q[63:0] + {32'd0, lo_q[63:32]};
  assign dmag = dsum[63:16];
  assign nw50 = {{18{w_q[31]}}, w_q} - dlt_q;
  assign nw   = lrgs_pkg::sat32(nw50);

  // RAM write controls
  always_comb begin
    w_we    = 1'b0;
    w_waddr = in_addr;
    w_wdata = in_data_i.value;
    x_we    = 1'b0;
    g_we    = 1'b0;
    if (in_fire && idx_ok) begin
      w_we = (in_data_i.op == lrgs_pkg::OP_LOAD_WEIGHT);
      x_we = (in_data_i.op == lrgs_pkg::OP_FEATURE) && (in_data_i.index != 4'd0);
    end
    if (state_q == S_G_ACC) begin
      g_we = 1'b1;
    end
    if ((state_q == S_U_OUT) && out_free) begin
      w_we    = 1'b1;
      w_waddr = cnt_q;
      w_wdata = nw;
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    gvalid_d = gvalid_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cnt_d = '0;
          acc_d = 64'sd0;
          if (in_data_i.op == lrgs_pkg::OP_TARGET) begin
            state_d = S_P_RD;
          end else if (in_data_i.op == lrgs_pkg::OP_STEP) begin
            state_d = S_U_RD;
          end
        end
      end
      S_P_RD:  state_d = S_P_MUL;
      S_P_MUL: state_d = S_P_ACC;
      S_P_ACC: begin
        acc_d = lrgs_pkg::sat_add64(acc_q, mul_q[63:0]);
        if (cnt_q == n_act) begin
          state_d = S_ERR;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_P_RD;
        end
      end
      S_ERR: begin
        cnt_d   = '0;
        state_d = S_G_RD;
      end
      S_G_RD:  state_d = S_G_MUL;
      S_G_MUL: state_d = S_G_ACC;
      S_G_ACC: begin
        gvalid_d[cnt_q] = 1'b1;
        if (cnt_q == n_act) begin
          state_d = S_IDLE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_G_RD;
        end
      end
      S_U_RD:  state_d = S_U_LO;
      S_U_LO:  state_d = S_U_M1;
      S_U_M1:  state_d = S_U_M2;
      S_U_M2:  state_d = S_U_SUM;
      S_U_SUM: state_d = S_U_OUT;
      S_U_OUT: begin
        if (out_free) begin
          if (cnt_q == n_act) begin
            gvalid_d = '0;
            state_d  = S_IDLE;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_U_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      gvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      gvalid_q <= gvalid_d;
      if ((state_q == S_U_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mul_q <= mul_a * mul_b;
    if (in_fire) begin
      target_q <= in_data_i.value;
    end
    if (state_q == S_ERR) begin
      err_q <= lrgs_pkg::sat32(err50);
    end
    if (state_q == S_G_MUL) begin
      g_q <= g_masked;
    end
    if (state_q == S_U_LO) begin
      w_q   <= w_rd;
      neg_q <= g_masked[63];
      mag_q <= g_masked[63] ? (64'd0 - g_masked) : g_masked;
    end
    if (state_q == S_U_M2) begin
      lo_q <= mul_q[63:0];
    end
    if (state_q == S_U_SUM) begin
      dlt_q <= neg_q ? -$signed({2'b00, dmag}) : $signed({2'b00, dmag});
    end
    if ((state_q == S_U_OUT) && out_free) begin
      out_q.weight_index <= 4'(cnt_q);
      out_q.weight_value <= nw;
      out_q.last         <= (cnt_q == n_act);
    end
  end

endmodule

// ----- hw/rtl/lrgs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for weights, sample features and gradient sums.
module lrgs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
